// ===== design/jfps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jfps_pkg
// Shared constants and types for the five-point Jacobi stencil sweep block.
// ----------------------------------------------------------------------------
package jfps_pkg;

    localparam int MAX_GRID   = 1024;
    localparam int MIN_GRID   = 3;
    localparam int GRID_W     = 11;
    localparam int POS_W      = $clog2(MAX_GRID);
    localparam int SAMPLE_W   = 32;
    localparam int SUM_W      = SAMPLE_W + 2;
    localparam int LINE_W     = 2 * SAMPLE_W;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = FIFO_AW + 1;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [GRID_W-1:0]  GRID_RESET      = GRID_W'(128);
    localparam logic [PADDR_W-1:0] REG_GRID_SIZE   = PADDR_W'(0);

    // Control bits that travel with a sample through the arithmetic stages.
    typedef struct packed {
        logic emit;   // sample completes an interior stencil
        logic last;   // completes the final interior point of the sweep
        logic wrap;   // final sample of the grid, sweep ends after it
    } stage_ctl_t;

    // Occupancy of the datapath stages beyond the first.
    typedef struct packed {
        logic s2_valid;
        logic s3_valid;
    } pipe_status_t;

    // One result beat; new_value sits in the lowest bits.
    typedef struct packed {
        logic                last_point;
        logic [SAMPLE_W-1:0] max_change;
        logic [SAMPLE_W-1:0] new_value;
    } result_t;

endpackage
`default_nettype wire

// ===== design/jfps_line_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jfps_line_ram
// Simple dual-port synchronous RAM, one write and one read port, registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module jfps_line_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== design/jfps_stencil_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jfps_stencil_dp
// Stencil arithmetic: neighbour window, four-point sum, floor average,
// absolute change and running maximum, one sample per cycle.
// ----------------------------------------------------------------------------
module jfps_stencil_dp
    import jfps_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s1_valid,
    input  wire stage_ctl_t          s1_ctl,
    input  wire logic [SAMPLE_W-1:0] s1_sample,
    input  wire logic [LINE_W-1:0]   rd_line,
    input  wire logic                clear_max,
    output logic      [LINE_W-1:0]   wr_line,
    output pipe_status_t             status,
    output logic                     push,
    output result_t                  push_data
);

    // Line word: upper half is the row two above, lower half the row above.
    logic [SAMPLE_W-1:0] mid0_reg, mid1_reg, up_reg;

    logic signed [SUM_W-1:0] sum_comb;
    logic signed [SUM_W-1:0] sum_reg;
    logic [SAMPLE_W-1:0]     centre_reg;
    stage_ctl_t              ctl2_reg;
    logic                    s2_valid_reg;

    logic [SAMPLE_W-1:0]     fresh_comb;
    logic [SAMPLE_W:0]       diff_comb;
    logic [SAMPLE_W-1:0]     mag_comb;
    logic [SAMPLE_W-1:0]     fresh_reg, mag_reg;
    stage_ctl_t              ctl3_reg;
    logic                    s3_valid_reg;

    logic [SAMPLE_W-1:0]     max_reg, max_next;

    // Stage 1: right neighbour arrives from the RAM, the rest from the window.
    assign sum_comb = SUM_W'(signed'(up_reg))
                    + SUM_W'(signed'(s1_sample))
                    + SUM_W'(signed'(mid1_reg))
                    + SUM_W'(signed'(rd_line[SAMPLE_W-1:0]));

    assign wr_line = {mid0_reg, s1_sample};

    always_ff @(posedge aclk) begin
        if (s1_valid) begin
            mid1_reg   <= mid0_reg;
            mid0_reg   <= rd_line[SAMPLE_W-1:0];
            up_reg     <= rd_line[LINE_W-1:SAMPLE_W];
            sum_reg    <= sum_comb;
            centre_reg <= mid0_reg;
            ctl2_reg   <= s1_ctl;
        end
    end

    // Stage 2: arithmetic shift gives the floor of the quarter.
    assign fresh_comb = sum_reg[SUM_W-1:2];
    assign diff_comb  = {fresh_comb[SAMPLE_W-1], fresh_comb}
                      - {centre_reg[SAMPLE_W-1], centre_reg};
    assign mag_comb   = diff_comb[SAMPLE_W] ? SAMPLE_W'(-diff_comb)
                                            : diff_comb[SAMPLE_W-1:0];

    always_ff @(posedge aclk) begin
        if (s2_valid_reg) begin
            fresh_reg <= fresh_comb;
            mag_reg   <= mag_comb;
            ctl3_reg  <= ctl2_reg;
        end
    end

    // Stage 3: running maximum and hand-off to the output queue.
    assign max_next = (mag_reg > max_reg) ? mag_reg : max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            max_reg      <= '0;
        end else begin
            s2_valid_reg <= s1_valid;
            s3_valid_reg <= s2_valid_reg;
            if (clear_max) begin
                max_reg <= '0;
            end else if (s3_valid_reg && ctl3_reg.emit) begin
                max_reg <= max_next;
            end else if (s3_valid_reg && ctl3_reg.wrap) begin
                max_reg <= '0;
            end
        end
    end

    assign push                 = s3_valid_reg && ctl3_reg.emit;
    assign push_data.new_value  = fresh_reg;
    assign push_data.max_change = max_next;
    assign push_data.last_point = ctl3_reg.last;

    assign status.s2_valid = s2_valid_reg;
    assign status.s3_valid = s3_valid_reg;

endmodule
`default_nettype wire

// ===== design/jfps_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jfps_fifo
// Small result queue that decouples the stencil pipeline from the receiver.
// ----------------------------------------------------------------------------
module jfps_fifo
    import jfps_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire result_t          push_data,
    input  wire logic             pop,
    output logic                  not_empty,
    output result_t               head,
    output logic      [CNT_W-1:0] count
);

    result_t              mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wptr_reg, rptr_reg;
    logic [CNT_W-1:0]     count_reg, count_next;

    always_comb begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + FIFO_AW'(1);
            end
            if (pop) begin
                rptr_reg <= rptr_reg + FIFO_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head      = mem[rptr_reg];
    assign count     = count_reg;

endmodule
`default_nettype wire

// ===== design/jacobi_five_point_stencil_sweep_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jacobi_five_point_stencil_sweep_top
// One Jacobi relaxation sweep of a square grid with a five-point stencil.
//
// Grid samples (signed Q15.16) enter in raster order on the s_ stream, one
// per beat. Every sample that completes the stencil of an interior point
// (row two or later, column one to N-2) yields one beat on the m_ stream
// carrying the floor average of the four neighbours and the largest absolute
// change seen so far in the sweep; tlast marks the final interior point.
// Boundary points give no beat. The grid side is set through the APB
// register grid_size (byte address 0); a write restarts the sweep. Values
// below 3 act as 3 and values above 1024 act as 1024.
//
// Throughput is one sample per clock while s_tready is high. The window lives
// in one line RAM of 1024 words of 64 bits (row above and row two above per
// column); each sample costs one read, issued one column ahead, and one
// write, so the single read port sets the rate. A result reaches m_tvalid
// through three arithmetic stages and the result queue: the RAM read
// completes in the first of them, and the last of them writes the queue.
// Results collect in an eight-entry queue; while the receiver stalls, s_tready
// drops once the queue and the in-flight samples would fill it, and nothing
// is lost. Reset empties the pipeline and queue, returns the position to the
// grid origin, clears the running maximum and sets grid_size to 128. The RAM
// is not cleared; only entries written earlier in the same sweep are used.
// ----------------------------------------------------------------------------
module jacobi_five_point_stencil_sweep_top
    import jfps_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // Input stream
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [31:0]        s_tdata,   // [31:0] sample
    // Result stream
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic      [63:0]        m_tdata,   // [31:0] new_value, [63:32] max_change
    output logic                    m_tlast,   // last_point
    // Configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    logic [GRID_W-1:0] grid_size_reg;
    logic [GRID_W-1:0] n_active;
    logic              cfg_write;
    logic              grid_sel;

    logic [POS_W-1:0]  row_reg, row_next;
    logic [POS_W-1:0]  col_reg, col_next;
    logic              col_end, row_end;
    logic [POS_W-1:0]  rd_addr;
    logic              s_accept;
    stage_ctl_t        ctl_comb;

    logic                s1_valid_reg;
    stage_ctl_t          s1_ctl_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic [POS_W-1:0]    s1_col_reg;

    logic [LINE_W-1:0]   rd_line, wr_line;
    pipe_status_t        status;
    logic                push;
    result_t             push_data;
    result_t             head;
    logic [CNT_W-1:0]    fifo_count;
    logic [CNT_W+1:0]    committed;

    // ------------------------------------------------------------------
    // Register port: registers are decoded by word, the byte lane bits
    // of the address are not looked at.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign grid_sel  = (paddr[PADDR_W-1:2] == REG_GRID_SIZE[PADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready && grid_sel;
    assign prdata    = grid_sel ? PDATA_W'(grid_size_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_size_reg <= GRID_RESET;
        end else if (cfg_write) begin
            grid_size_reg <= pwdata[GRID_W-1:0];
        end
    end

    assign n_active = (grid_size_reg < GRID_W'(MIN_GRID)) ? GRID_W'(MIN_GRID) :
                      (grid_size_reg > GRID_W'(MAX_GRID)) ? GRID_W'(MAX_GRID) :
                      grid_size_reg;

    // ------------------------------------------------------------------
    // Raster position and stencil classification
    // ------------------------------------------------------------------
    assign s_accept = s_tvalid && s_tready;
    assign col_end  = ({1'b0, col_reg} == n_active - GRID_W'(1));
    assign row_end  = ({1'b0, row_reg} == n_active - GRID_W'(1));

    assign ctl_comb.emit = (row_reg >= POS_W'(2)) && (col_reg != '0)
                        && ({1'b0, col_reg} <= n_active - GRID_W'(2));
    assign ctl_comb.last = row_end && ({1'b0, col_reg} == n_active - GRID_W'(2));
    assign ctl_comb.wrap = row_end && col_end;

    always_comb begin
        col_next = col_reg + POS_W'(1);
        row_next = row_reg;
        if (col_end) begin
            col_next = '0;
            row_next = row_end ? '0 : row_reg + POS_W'(1);
        end
    end

    // The right-hand neighbour of the centre is fetched one column ahead;
    // at the end of a row the fetch wraps to column zero of the next row.
    assign rd_addr = col_end ? '0 : col_reg + POS_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s_accept;
            if (cfg_write) begin
                row_reg <= '0;
                col_reg <= '0;
            end else if (s_accept) begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_ctl_reg    <= ctl_comb;
            s1_sample_reg <= s_tdata;
            s1_col_reg    <= col_reg;
        end
    end

    // ------------------------------------------------------------------
    // Line RAM: a column is read again no sooner than two samples after the
    // sample that writes it, so no forwarding is needed even on the smallest grid.
    // ------------------------------------------------------------------
    jfps_line_ram #(
        .DEPTH (MAX_GRID),
        .WIDTH (LINE_W)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (wr_line),
        .re    (s_accept),
        .raddr (rd_addr),
        .rdata (rd_line)
    );

    jfps_stencil_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s1_valid  (s1_valid_reg),
        .s1_ctl    (s1_ctl_reg),
        .s1_sample (s1_sample_reg),
        .rd_line   (rd_line),
        .clear_max (cfg_write),
        .wr_line   (wr_line),
        .status    (status),
        .push      (push),
        .push_data (push_data)
    );

    // ------------------------------------------------------------------
    // Result queue and flow control: every sample in flight may still
    // need a slot, so they are counted against the free space.
    // ------------------------------------------------------------------
    jfps_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (m_tvalid && m_tready),
        .not_empty (m_tvalid),
        .head      (head),
        .count     (fifo_count)
    );

    assign committed = (CNT_W+2)'(fifo_count)
                     + (CNT_W+2)'(s1_valid_reg)
                     + (CNT_W+2)'(status.s2_valid)
                     + (CNT_W+2)'(status.s3_valid);
    assign s_tready  = (committed < (CNT_W+2)'(FIFO_DEPTH));

    assign m_tdata = {head.max_change, head.new_value};
    assign m_tlast = head.last_point;

endmodule
`default_nettype wire

// ===== design/jfps_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jfps_checker
// Port-level checks on the stencil sweep block, bound to the top level.
// ----------------------------------------------------------------------------
module jfps_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [63:0]        m_tdata,
    input wire logic               m_tlast,
    input wire logic               psel,
    input wire logic               penable,
    input wire logic               pwrite,
    input wire logic               pready
);

    // Last delivered maximum within the current sweep.
    logic        prev_valid_reg;
    logic [31:0] prev_max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_valid_reg <= 1'b0;
        end else if (psel && penable && pwrite) begin
            prev_valid_reg <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            prev_valid_reg <= !m_tlast;
            prev_max_reg   <= m_tdata[63:32];
        end
    end

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat offered straight after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result beat changed or withdrawn");

    a_max_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && prev_valid_reg |-> m_tdata[63:32] >= prev_max_reg)
        else $error("maximum change fell within a sweep");

    a_ready_reg_port: assert property (@(posedge aclk) disable iff (!aresetn)
        psel |-> pready)
        else $error("register port stalled");

endmodule

bind jacobi_five_point_stencil_sweep_top jfps_checker u_jfps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready)
);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the five-point Jacobi stencil sweep block.
//
// Grid samples are streamed in raster order under several grid sizes. These
// include the reset size, the smallest grid, sizes below and above the legal
// range and the largest grid. A scoreboard keeps its own copy of the sample
// window and the sweep position. From each accepted sample it works out the
// interior point that the sample completes, if any. Every result beat is
// then checked field by field against the oldest prediction. The grid_size
// register is read back after every write. Both stream sides pause at random
// in the first two thirds of the run, with a different mix in each, and never in the last.
// ----------------------------------------------------------------------------
module tb_top
    import jfps_pkg::*;
();

    // The window spans two full rows plus one sample, as in the block.
    localparam int WIN_DEPTH   = 2 * MAX_GRID + 1;
    localparam int DRAIN       = 12;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [GRID_W-1:0] GRID_ALL_ONES = '1;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts one sweep sample by sample and keeps the queue of
    // interior points still owed by the block.
    // ------------------------------------------------------------------------
    class sweep_scoreboard;
        logic [SAMPLE_W-1:0] window [WIN_DEPTH];
        logic [GRID_W-1:0]   grid_reg;
        int unsigned         row;
        int unsigned         col;
        logic [SAMPLE_W-1:0] peak_change;
        result_t             owed_points [$];
        int                  errors;

        function new();
            foreach (window[i]) window[i] = '0;
            grid_reg = GRID_RESET;
            errors   = 0;
            restart();
        endfunction

        function void restart();
            row         = 0;
            col         = 0;
            peak_change = '0;
        endfunction

        // Any write to the register starts a fresh sweep.
        function void set_grid(logic [GRID_W-1:0] v);
            grid_reg = v;
            restart();
        endfunction

        function int unsigned side();
            if (grid_reg < MIN_GRID) return MIN_GRID;
            if (grid_reg > MAX_GRID) return MAX_GRID;
            return 32'(grid_reg);
        endfunction

        function longint word_at(int unsigned k);
            longint w;
            w = $signed(window[k % WIN_DEPTH]);
            return w;
        endfunction

        // Stores the sample and, when it is the lower neighbour of an
        // interior point, queues that point's floor average and the running
        // largest change.
        function void take_sample(logic [SAMPLE_W-1:0] s);
            int unsigned n, r, c, k, mid;
            longint      sum, fresh, diff, span;
            result_t     want;
            n = side();
            r = row;
            c = col;
            if (r >= n || c >= n) begin
                r = 0;
                c = 0;
            end
            k = r * n + c;
            window[k % WIN_DEPTH] = s;
            if (r >= 2 && c >= 1 && c <= n - 2) begin
                mid   = k - n;
                sum   = word_at(k) + word_at(k - 2 * n) + word_at(mid - 1) + word_at(mid + 1);
                // An arithmetic shift of the full-width sum floors the quarter.
                fresh = sum >>> 2;
                diff  = fresh - word_at(mid);
                span  = (diff < 0) ? -diff : diff;
                if (span[31:0] > peak_change) peak_change = span[31:0];
                want.new_value  = fresh[31:0];
                want.max_change = peak_change;
                want.last_point = (r == n - 1 && c == n - 2);
                owed_points.push_back(want);
            end
            c++;
            if (c == n) begin
                c = 0;
                r++;
                if (r == n) begin
                    r           = 0;
                    peak_change = '0;
                end
            end
            row = r;
            col = c;
        endfunction

        function void check_point(result_t got);
            result_t want;
            if (owed_points.size() == 0) begin
                $display("%0t: result beat with none owed: expected nothing, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = owed_points.pop_front();
            if (got.new_value !== want.new_value) begin
                $display("%0t: new_value expected %h actual %h",
                         $time, want.new_value, got.new_value);
                errors++;
            end
            if (got.max_change !== want.max_change) begin
                $display("%0t: max_change expected %h actual %h",
                         $time, want.max_change, got.max_change);
                errors++;
            end
            if (got.last_point !== want.last_point) begin
                $display("%0t: last_point expected %b actual %b",
                         $time, want.last_point, got.last_point);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs. Every input has a known value at time 0.
    // ------------------------------------------------------------------------
    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [31:0]        s_tdata  = '0;   // [31:0] sample
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [63:0]        m_tdata;         // [31:0] new_value, [63:32] max_change
    logic               m_tlast;         // last_point
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr    = '0;
    logic [PDATA_W-1:0] pwdata   = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int unsigned cycle_count    = 0;
    int          sender_idle    = 0;
    int          receiver_idle  = 0;

    sweep_scoreboard sb = new();

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    jacobi_five_point_stencil_sweep_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // The receiver holds off on a fresh random draw every cycle.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= receiver_idle);
    end

    // Both streams are observed at the clock edge, before any of this edge's
    // updates land, so a beat counts exactly when the block sees it.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.take_sample(s_tdata);
            if (m_tvalid && m_tready) sb.check_point({m_tlast, m_tdata});
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("jacobi_five_point_stencil_sweep_top: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers. Each task starts and ends just after a rising edge.
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic [31:0] v);
        while ($urandom_range(0, 99) < sender_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Random full-range values, with the extremes and small values of both
    // signs mixed in so that sums and changes reach their limits.
    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'($urandom_range(0, 32'h3FFFF));
            5:       return -32'($urandom_range(0, 32'h3FFFF));
            default: return $urandom();
        endcase
    endfunction

    task automatic feed_random(input int count);
        for (int i = 0; i < count; i++) send_sample(pick_sample());
    endtask

    // Wait until every owed point has come back, then let the pipeline settle:
    // the last samples of a phase may still be in flight without a result.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.owed_points.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] a, input logic [PDATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_readback(input logic [GRID_W-1:0] want);
        logic [PDATA_W-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= REG_GRID_SIZE;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== PDATA_W'(want)) begin
            $display("%0t: grid_size readback expected %h actual %h",
                     $time, PDATA_W'(want), got);
            sb.errors++;
        end
    endtask

    // A write restarts the sweep, so it only happens once the block is idle.
    task automatic program_grid(input int side);
        drain();
        apb_write(REG_GRID_SIZE, PDATA_W'(side));
        sb.set_grid(GRID_W'(side));
        check_readback(GRID_W'(side));
    endtask

    // Random phases: mostly small grids fed for one or two sweeps plus a
    // partial one, now and then an undersized grid or a wider grid fed just
    // past its first interior rows.
    task automatic random_phases(input int target);
        int done, side, eff, count;
        done = 0;
        while (done < target) begin
            case ($urandom_range(0, 9))
                0:       side = $urandom_range(0, MIN_GRID - 1);
                1:       side = $urandom_range(17, 48);
                default: side = $urandom_range(MIN_GRID, 16);
            endcase
            eff = (side < MIN_GRID) ? MIN_GRID : side;
            if (eff > 16) begin
                count = 2 * eff + $urandom_range(1, 2 * eff);
            end else begin
                count = eff * eff * $urandom_range(1, 2) + $urandom_range(0, eff * eff);
            end
            program_grid(side);
            feed_random(count);
            done += count;
        end
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        sender_idle   = sender_pct;
        receiver_idle = receiver_pct;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // First third: the sender rarely pauses, the receiver mostly stalls.
        set_idling(11, 82);

        // The reset grid size is used without any write, just past the
        // first interior row.
        check_readback(GRID_RESET);
        feed_random(2 * int'(GRID_RESET) + 10);

        // Smallest grid, three sweeps with a single interior point each.
        // All samples at the positive limit give no change at all.
        program_grid(MIN_GRID);
        for (int i = 0; i < 9; i++) send_sample(32'h7FFF_FFFF);
        // Neighbours at the negative limit around a centre at the positive
        // limit give the widest possible change; the running maximum must
        // still start from zero in the next sweep.
        for (int i = 0; i < 9; i++) send_sample((i == 4) ? 32'h7FFF_FFFF : 32'h8000_0000);
        // A single neighbour of -1 must floor the quarter to -1, not 0.
        for (int i = 0; i < 9; i++) send_sample((i == 1) ? 32'hFFFF_FFFF : 32'h0000_0000);

        // A size below the minimum acts as the minimum; the following write
        // lands part way through the second sweep and must restart it.
        program_grid(MIN_GRID - 1);
        feed_random(11);

        random_phases(380);

        // Second third: the sender mostly pauses, the receiver rarely. The
        // largest grid only gets part of its first row, so no beat is owed.
        set_idling(82, 11);
        program_grid(MAX_GRID);
        feed_random(64);
        random_phases(380);

        // Last third: no pauses on either side. A size above the maximum,
        // with every register bit set, acts as the maximum and, fed only
        // part of its first row, owes no beat either.
        set_idling(0, 0);
        program_grid(int'(GRID_ALL_ONES));
        feed_random(64);
        random_phases(380);

        drain();
        if (sb.errors == 0 && sb.owed_points.size() == 0) begin
            $display("jacobi_five_point_stencil_sweep_top: match");
        end else begin
            $display("jacobi_five_point_stencil_sweep_top: mismatch");
        end
        $finish;
    end

endmodule

// ===== jacobi_five_point_stencil_sweep_top.f =====
design/jfps_pkg.sv
design/jfps_line_ram.sv
design/jfps_stencil_dp.sv
design/jfps_fifo.sv
design/jacobi_five_point_stencil_sweep_top.sv
design/jfps_checker.sv
tb/sv/tb_top.sv
